### hw/rtl/ecda_pkg.sv
// ----------------------------------------------------------------------------
// ecda_pkg: shared types and constants of the eye closure alarm
// Point and ratio formats, engine status and sequencer states.
// ----------------------------------------------------------------------------
package ecda_pkg;

   // Coordinates: input field width and the number of bits in use
   localparam int PT_W       = 10;
   localparam int COORD_BITS = 10;
   localparam logic [PT_W-1:0] COORD_MASK =
      (COORD_BITS >= PT_W) ? {PT_W{1'b1}} : PT_W'((1 << COORD_BITS) - 1);

   // Square of one coordinate difference, and the sum of two of them
   localparam int SQ_W   = 2 * PT_W;
   localparam int SUM_W  = SQ_W + 1;
   // Radicand is the sum with 12 fraction bits, rounded up to an even width
   localparam int FRAC_W = 12;
   localparam int RAD_W  = ((SUM_W + FRAC_W + 1) / 2) * 2;
   localparam int ROOT_W = RAD_W / 2;
   localparam int ROOT_N = RAD_W / 2;
   localparam int CNT_W  = $clog2(ROOT_N + 1);

   // Ratio division: numerator (a + b) << 12, denominator 2 * c
   localparam int NUM_W   = ROOT_W + 1 + FRAC_W;
   localparam int DEN_W   = ROOT_W + 1;
   localparam int RATIO_W = 16;

   // Width of the shared compare and subtract unit
   localparam int STEP_W = ((RAD_W > DEN_W + RATIO_W) ? RAD_W : DEN_W + RATIO_W) + 1;

   // Configuration
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DAT_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_RATIO_THRESHOLD = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_SECONDS    = CSR_IDX_W'(1);
   localparam logic [RATIO_W-1:0]   THRESHOLD_RESET     = RATIO_W'(819);
   localparam logic [7:0]           HOLD_RESET          = 8'd2;

   // Frame layout
   localparam int EYE_POINTS   = 6;
   localparam int FRAME_POINTS = 12;

   typedef struct packed {
      logic [PT_W-1:0] x;
      logic [PT_W-1:0] y;
   } point_type;

   typedef point_type [EYE_POINTS-1:0] point_set_type;

   typedef struct packed {
      logic               done;
      logic [RATIO_W-1:0] ratio;
   } eng_result_type;

   typedef enum logic [2:0] {
      ENG_IDLE,
      ENG_LOAD,
      ENG_SQX,
      ENG_SQY,
      ENG_ROOT,
      ENG_DIVCHK,
      ENG_DIV,
      ENG_DONE
   } eng_state_type;

endpackage

### hw/rtl/eye_closure_drowsiness_alarm.sv
// ----------------------------------------------------------------------------
// eye_closure_drowsiness_alarm: eye aspect ratio drowsiness detector
// Collects twelve landmark points a frame, rates both eyes, averages the
// ratios and tracks the closed streak to raise the alarm.
// ----------------------------------------------------------------------------
// One point a cycle while the request side is ready, but the sixth and twelfth
// start the ratio engine: three distances (load, two squares, 17 root steps), a
// saturation check, 16 division steps and a finish, the division skipped when a
// saturated ratio comes out of the check. The sixth point holds the request side
// until the engine is done, the twelfth until its result is registered for output.
// Synchronous reset clears point count, streak and alarm and restores the configuration defaults.
// ----------------------------------------------------------------------------
module eye_closure_drowsiness_alarm
   import ecda_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // Point requests
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [55:0]          req_tdata,   // point_x[9:0], point_y[19:10],
                                             // now_seconds[51:20], zero[55:52]
   input  logic                 req_tuser,   // frame_first
   // Frame results
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [23:0]          rsp_tdata,   // alarm[0], eyes_closed[1],
                                             // mean_ratio[17:2], zero[23:18]
   // Configuration writes
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data
);

   logic [RATIO_W-1:0] thr_ff, thr_in;
   logic [7:0]         hold_ff, hold_in;
   logic [3:0]         count_ff, count_in;
   logic               busy_ff, busy_in;
   logic               start_ff, start_in;
   logic               right_eye_ff, right_eye_in;
   logic               fin_ff, fin_in;
   logic               closed_before_ff, closed_before_in;
   logic [31:0]        closed_since_ff, closed_since_in;
   logic               alarm_ff, alarm_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [23:0]        rsp_data_ff, rsp_data_in;
   logic [RATIO_W-1:0] left_ff, left_in, right_ff, right_in;
   logic [31:0]        now_ff, now_in;
   point_set_type      store_ff;

   eng_result_type     eng;
   logic               req_acc;
   logic [3:0]         base;
   logic [3:0]         count_next;
   logic [2:0]         slot;
   logic               commit;
   logic [RATIO_W:0]   sum;
   logic [RATIO_W-1:0] mean;
   logic               closed;
   logic [31:0]        elapsed;

   ecda_ratio_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .start  (start_ff),
      .points (store_ff),
      .result (eng)
   );

   assign req_tready = ~busy_ff;
   assign req_acc    = req_tvalid & ~busy_ff;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Point position within the frame
   assign base       = (req_tuser || count_ff > 4'(FRAME_POINTS - 1)) ? 4'd0 : count_ff;
   assign slot       = (base >= 4'(EYE_POINTS)) ? 3'(base - 4'(EYE_POINTS)) : base[2:0];
   assign count_next = base + 4'd1;

   // Frame decision from both ratios
   assign sum     = {1'b0, left_ff} + {1'b0, right_ff};
   assign mean    = sum[RATIO_W:1];
   assign closed  = mean < thr_ff;
   assign elapsed = now_ff - closed_since_ff;
   assign commit  = fin_ff & (~rsp_valid_ff | rsp_tready);

   always_comb begin
      thr_in           = thr_ff;
      hold_in          = hold_ff;
      count_in         = count_ff;
      busy_in          = busy_ff;
      start_in         = 1'b0;
      right_eye_in     = right_eye_ff;
      fin_in           = fin_ff;
      closed_before_in = closed_before_ff;
      closed_since_in  = closed_since_ff;
      alarm_in         = alarm_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_data_in      = rsp_data_ff;
      left_in          = left_ff;
      right_in         = right_ff;
      now_in           = now_ff;

      // Register writes
      if (csr_valid) begin
         case (csr_index)
            CSR_RATIO_THRESHOLD: thr_in  = csr_data;
            CSR_HOLD_SECONDS:    hold_in = csr_data[7:0];
            default:             ;
         endcase
      end

      // Drop a taken result
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // Count the point; launch the engine at the end of each eye
      if (req_acc) begin
         count_in = count_next;
         if (count_next == 4'(EYE_POINTS)) begin
            busy_in      = 1'b1;
            start_in     = 1'b1;
            right_eye_in = 1'b0;
         end else if (count_next == 4'(FRAME_POINTS)) begin
            count_in     = 4'd0;
            busy_in      = 1'b1;
            start_in     = 1'b1;
            right_eye_in = 1'b1;
            now_in       = req_tdata[51:20];
         end
      end

      // Take the engine ratio
      if (eng.done) begin
         if (right_eye_ff) begin
            right_in = eng.ratio;
            fin_in   = 1'b1;
         end else begin
            left_in  = eng.ratio;
            busy_in  = 1'b0;
         end
      end

      // Update the streak and present the result
      if (commit) begin
         fin_in  = 1'b0;
         busy_in = 1'b0;
         if (closed) begin
            if (closed_before_ff) begin
               if (elapsed >= {24'd0, hold_ff}) begin
                  alarm_in = 1'b1;
               end
            end else begin
               closed_since_in = now_ff;
            end
            closed_before_in = 1'b1;
         end else begin
            closed_before_in = 1'b0;
            alarm_in         = 1'b0;
         end
         rsp_valid_in = 1'b1;
         rsp_data_in  = {6'd0, mean, closed, alarm_in};
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff           <= THRESHOLD_RESET;
         hold_ff          <= HOLD_RESET;
         count_ff         <= 4'd0;
         busy_ff          <= 1'b0;
         start_ff         <= 1'b0;
         fin_ff           <= 1'b0;
         closed_before_ff <= 1'b0;
         closed_since_ff  <= 32'd0;
         alarm_ff         <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         thr_ff           <= thr_in;
         hold_ff          <= hold_in;
         count_ff         <= count_in;
         busy_ff          <= busy_in;
         start_ff         <= start_in;
         fin_ff           <= fin_in;
         closed_before_ff <= closed_before_in;
         closed_since_ff  <= closed_since_in;
         alarm_ff         <= alarm_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      right_eye_ff <= right_eye_in;
      rsp_data_ff  <= rsp_data_in;
      left_ff      <= left_in;
      right_ff     <= right_in;
      now_ff       <= now_in;
   end

   // Point store, written at the slot of the current eye
   always_ff @(posedge clock) begin
      if (req_acc) begin
         store_ff[slot].x <= req_tdata[9:0] & COORD_MASK;
         store_ff[slot].y <= req_tdata[19:10] & COORD_MASK;
      end
   end

endmodule

### hw/rtl/ecda_cmp_sub.sv
// ----------------------------------------------------------------------------
// ecda_cmp_sub: shared compare and subtract unit
// Gives a - b and whether a >= b; used by every root and division step.
// ----------------------------------------------------------------------------
module ecda_cmp_sub
   import ecda_pkg::*;
(
   input  logic [STEP_W-1:0] op_a,
   input  logic [STEP_W-1:0] op_b,
   output logic [STEP_W-1:0] diff,
   output logic              ge
);

   logic [STEP_W:0] wide;

   // Borrow out of the subtraction decides the compare
   assign wide = {1'b0, op_a} - {1'b0, op_b};
   assign diff = wide[STEP_W-1:0];
   assign ge   = ~wide[STEP_W];

endmodule

### hw/rtl/ecda_ratio_engine.sv
// ----------------------------------------------------------------------------
// ecda_ratio_engine: eye aspect ratio sequencer
// Three distances by squaring and a bit-pair square root, then a 16-step
// restoring division, all through one compare and subtract unit.
// ----------------------------------------------------------------------------
module ecda_ratio_engine
   import ecda_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  point_set_type  points,
   output eng_result_type result
);

   eng_state_type state_ff, state_in;
   logic [1:0]          k_ff, k_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [PT_W-1:0]     dx_ff, dx_in, dy_ff, dy_in;
   logic [SUM_W-1:0]    acc_ff, acc_in;
   logic [RAD_W-1:0]    rad_ff, rad_in, res_ff, res_in, bit_ff, bit_in;
   logic [ROOT_W-1:0]   dist_ff [3];
   logic [ROOT_W-1:0]   dist_in [3];
   logic [NUM_W-1:0]    num_ff, num_in;
   logic [DEN_W-1:0]    den_ff, den_in;
   logic [DEN_W-1:0]    rem_ff, rem_in;
   logic [RATIO_W-1:0]  quo_ff, quo_in, ratio_ff, ratio_in;
   logic                done;

   point_type           pa, pb;
   logic [PT_W-1:0]     mul_op;
   logic [SQ_W-1:0]     sq;
   logic [STEP_W-1:0]   op_a, op_b, diff;
   logic                ge;
   logic [RAD_W-1:0]    trial;
   logic [NUM_W-1:0]    num_new;
   logic [DEN_W-1:0]    den_new;
   logic [DEN_W:0]      div_t;

   ecda_cmp_sub u_cmp_sub (
      .op_a (op_a),
      .op_b (op_b),
      .diff (diff),
      .ge   (ge)
   );

   // Pick the point pair of the current distance: p1-p5, p2-p4, p0-p3
   always_comb begin
      case (k_ff)
         2'd0: begin
            pa = points[1];
            pb = points[5];
         end
         2'd1: begin
            pa = points[2];
            pb = points[4];
         end
         default: begin
            pa = points[0];
            pb = points[3];
         end
      endcase
   end

   // One squarer, shared between the x and y differences
   assign mul_op  = (state_ff == ENG_SQX) ? dx_ff : dy_ff;
   assign sq      = {{PT_W{1'b0}}, mul_op} * {{PT_W{1'b0}}, mul_op};
   assign trial   = res_ff + bit_ff;
   assign num_new = NUM_W'({1'b0, dist_ff[0]} + {1'b0, dist_ff[1]}) << FRAC_W;
   assign den_new = {dist_ff[2], 1'b0};
   assign div_t   = {rem_ff, num_ff[RATIO_W-1]};

   // Route the shared unit operands by step
   always_comb begin
      case (state_ff)
         ENG_ROOT: begin
            op_a = STEP_W'(rad_ff);
            op_b = STEP_W'(trial);
         end
         ENG_DIVCHK: begin
            op_a = STEP_W'(num_new);
            op_b = STEP_W'({den_new, {RATIO_W{1'b0}}});
         end
         ENG_DIV: begin
            op_a = STEP_W'(div_t);
            op_b = STEP_W'(den_ff);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   // Sequencer: next state and datapath updates
   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      cnt_in   = cnt_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      acc_in   = acc_ff;
      rad_in   = rad_ff;
      res_in   = res_ff;
      bit_in   = bit_ff;
      dist_in  = dist_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      ratio_in = ratio_ff;
      done     = 1'b0;
      case (state_ff)
         ENG_IDLE: begin
            if (start) begin
               k_in     = 2'd0;
               state_in = ENG_LOAD;
            end
         end
         ENG_LOAD: begin
            dx_in    = (pa.x > pb.x) ? pa.x - pb.x : pb.x - pa.x;
            dy_in    = (pa.y > pb.y) ? pa.y - pb.y : pb.y - pa.y;
            state_in = ENG_SQX;
         end
         ENG_SQX: begin
            acc_in   = SUM_W'(sq);
            state_in = ENG_SQY;
         end
         ENG_SQY: begin
            rad_in   = RAD_W'(acc_ff + SUM_W'(sq)) << FRAC_W;
            res_in   = '0;
            bit_in   = RAD_W'(1) << (RAD_W - 2);
            cnt_in   = '0;
            state_in = ENG_ROOT;
         end
         ENG_ROOT: begin
            // Try the next root bit; keep it when the remainder allows
            if (ge) begin
               rad_in = diff[RAD_W-1:0];
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(ROOT_N - 1)) begin
               dist_in[k_ff] = res_in[ROOT_W-1:0];
               if (k_ff == 2'd2) begin
                  state_in = ENG_DIVCHK;
               end else begin
                  k_in     = k_ff + 2'd1;
                  state_in = ENG_LOAD;
               end
            end
         end
         ENG_DIVCHK: begin
            // Zero width eye or a quotient past 16 bits saturates
            num_in = num_new;
            den_in = den_new;
            rem_in = DEN_W'(num_new >> RATIO_W);
            quo_in = '0;
            cnt_in = '0;
            if (dist_ff[2] == '0 || ge) begin
               ratio_in = {RATIO_W{1'b1}};
               state_in = ENG_DONE;
            end else begin
               state_in = ENG_DIV;
            end
         end
         ENG_DIV: begin
            rem_in = ge ? diff[DEN_W-1:0] : div_t[DEN_W-1:0];
            quo_in = {quo_ff[RATIO_W-2:0], ge};
            num_in = num_ff << 1;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(RATIO_W - 1)) begin
               ratio_in = quo_in;
               state_in = ENG_DONE;
            end
         end
         ENG_DONE: begin
            done     = 1'b1;
            state_in = ENG_IDLE;
         end
         default: begin
            state_in = ENG_IDLE;
         end
      endcase
   end

   // Hold the sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ENG_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      k_ff     <= k_in;
      cnt_ff   <= cnt_in;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      acc_ff   <= acc_in;
      rad_ff   <= rad_in;
      res_ff   <= res_in;
      bit_ff   <= bit_in;
      dist_ff  <= dist_in;
      num_ff   <= num_in;
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      ratio_ff <= ratio_in;
   end

   assign result.done  = done;
   assign result.ratio = ratio_ff;

endmodule

### verif/tb_eye_closure_drowsiness_alarm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_eye_closure_drowsiness_alarm: self-checking bench for the eye closure alarm
// Streams landmark frames, predicts every frame result in a scoreboard and
// compares it field by field, under random idling on both sides and a range
// of threshold and hold settings.
// ----------------------------------------------------------------------------
module tb_eye_closure_drowsiness_alarm;
   import ecda_pkg::*;

   localparam int IDLE_CYCLES  = 200;
   localparam int PHASE_POINTS = 175;

   typedef struct packed {
      logic [RATIO_W-1:0] mean_ratio;
      logic               eyes_closed;
      logic               alarm;
   } frame_result_type;

   // Predicts frame results from accepted points and holds them until checked
   class frame_result_tracker;
      logic [RATIO_W-1:0] threshold;
      logic [7:0]         hold_s;
      int                 pt_x[EYE_POINTS];
      int                 pt_y[EYE_POINTS];
      int                 count;
      logic [RATIO_W-1:0] left_q;
      bit                 closed_before;
      logic [31:0]        closed_since;
      bit                 alarm_on;
      frame_result_type   pending_results[$];
      int                 errors;
      int                 frames_seen;
      int                 closed_seen;
      int                 alarms_seen;

      function new();
         threshold     = THRESHOLD_RESET;
         hold_s        = HOLD_RESET;
         count         = 0;
         left_q        = '0;
         closed_before = 0;
         closed_since  = '0;
         alarm_on      = 0;
         errors        = 0;
         frames_seen   = 0;
         closed_seen   = 0;
         alarms_seen   = 0;
      endfunction

      // Distance between two stored points, 6 fraction bits
      function logic [63:0] dist_q6(int i, int j);
         logic [63:0] dx, dy, rad, root, cand;
         dx   = (pt_x[i] > pt_x[j]) ? pt_x[i] - pt_x[j] : pt_x[j] - pt_x[i];
         dy   = (pt_y[i] > pt_y[j]) ? pt_y[i] - pt_y[j] : pt_y[j] - pt_y[i];
         rad  = (dx * dx + dy * dy) << FRAC_W;
         root = '0;
         // build the root one bit at a time, keeping root*root <= rad
         for (int b = 17; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            if (cand * cand <= rad)
               root = cand;
         end
         return root;
      endfunction

      // Aspect ratio of the eye held in the store, Q4.12, saturated
      function logic [RATIO_W-1:0] eye_ratio();
         logic [63:0] lid_a, lid_b, width, quot;
         lid_a = dist_q6(1, 5);
         lid_b = dist_q6(2, 4);
         width = dist_q6(0, 3);
         if (width == 0)
            return '1;
         quot = ((lid_a + lid_b) << FRAC_W) / (2 * width);
         return (quot > 64'hFFFF) ? '1 : quot[RATIO_W-1:0];
      endfunction

      function void take_point(logic [PT_W-1:0] x, logic [PT_W-1:0] y, bit first,
                               logic [31:0] now);
         int                 slot;
         logic [RATIO_W-1:0] right_q;
         logic [RATIO_W:0]   ratio_sum;
         logic [31:0]        elapsed;
         frame_result_type   res;
         if (first || count >= FRAME_POINTS)
            count = 0;
         slot       = count % EYE_POINTS;
         pt_x[slot] = int'(x & COORD_MASK);
         pt_y[slot] = int'(y & COORD_MASK);
         count++;
         if (count == EYE_POINTS) begin
            left_q = eye_ratio();
         end else if (count == FRAME_POINTS) begin
            count           = 0;
            right_q         = eye_ratio();
            ratio_sum       = left_q + right_q;
            res.mean_ratio  = ratio_sum[RATIO_W:1];
            res.eyes_closed = res.mean_ratio < threshold;
            // track the closed streak; the alarm never fires on its first frame
            if (res.eyes_closed) begin
               if (closed_before) begin
                  elapsed = now - closed_since;
                  if (elapsed >= hold_s)
                     alarm_on = 1;
               end else begin
                  closed_since = now;
               end
               closed_before = 1;
            end else begin
               closed_before = 0;
               alarm_on      = 0;
            end
            res.alarm = alarm_on;
            pending_results = {pending_results, res};
         end
      endfunction

      function void compare_field(string name, logic [RATIO_W-1:0] want,
                                  logic [RATIO_W-1:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         end
      endfunction

      function void match_result(logic [23:0] data);
         frame_result_type got, want;
         got = data[17:0];
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected frame result, expected none actual %h", $time, data);
            return;
         end
         want = pending_results.pop_front();
         frames_seen++;
         closed_seen += got.eyes_closed;
         alarms_seen += got.alarm;
         compare_field("alarm", want.alarm, got.alarm);
         compare_field("eyes_closed", want.eyes_closed, got.eyes_closed);
         compare_field("mean_ratio", want.mean_ratio, got.mean_ratio);
      endfunction
   endclass

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [55:0]          req_tdata  = '0;
   logic                 req_tuser  = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [23:0]          rsp_tdata;
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [CSR_DAT_W-1:0] csr_data   = '0;

   frame_result_tracker sb = new();

   int          points_sent      = 0;
   int          settings_written = 0;
   bit          no_gaps          = 0;
   bit          closed_mode      = 0;
   logic [31:0] wall_s           = '0;
   int          frame_x[FRAME_POINTS];
   int          frame_y[FRAME_POINTS];

   eye_closure_drowsiness_alarm dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Mostly no gap, often a short one, now and then a long one
   function automatic int pick_gap();
      int r;
      if (no_gaps)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 65)
         return 0;
      if (r < 94)
         return $urandom_range(1, 4);
      return $urandom_range(15, 120);
   endfunction

   // Send one point request and note it once accepted
   task automatic send_point(input int x, input int y, input bit first,
                             input logic [31:0] now);
      int gap;
      req_tdata  <= {4'b0, now, y[PT_W-1:0], x[PT_W-1:0]};
      req_tuser  <= first;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.take_point(x[PT_W-1:0], y[PT_W-1:0], first, now);
      points_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_RATIO_THRESHOLD)
         sb.threshold = value;
      else
         sb.hold_s = value[7:0];
      settings_written++;
      @(posedge clock);
   endtask

   // Drop the request side and let every expected result and any ratio run finish
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (IDLE_CYCLES) @(posedge clock);
   endtask

   // Six points of one eye: corners, upper lid, lower lid; sometimes pure noise
   function automatic void fill_eye(int base, bit shut);
      int cx, cy, hw, h;
      if ($urandom_range(0, 9) == 0) begin
         for (int i = 0; i < EYE_POINTS; i++) begin
            frame_x[base + i] = $urandom_range(0, 1023);
            frame_y[base + i] = $urandom_range(0, 1023);
         end
         return;
      end
      cx = $urandom_range(120, 900);
      cy = $urandom_range(120, 900);
      hw = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(8, 100);
      if (hw == 0)
         h = $urandom_range(0, 20);
      else
         h = shut ? $urandom_range(0, hw / 4) : $urandom_range(hw / 5, hw / 2);
      frame_x[base + 0] = cx - hw;     frame_y[base + 0] = cy;
      frame_x[base + 1] = cx - hw / 2; frame_y[base + 1] = cy - h - $urandom_range(0, 2);
      frame_x[base + 2] = cx + hw / 2; frame_y[base + 2] = cy - h - $urandom_range(0, 2);
      frame_x[base + 3] = cx + hw;     frame_y[base + 3] = cy;
      frame_x[base + 4] = cx + hw / 2; frame_y[base + 4] = cy + h + $urandom_range(0, 2);
      frame_x[base + 5] = cx - hw / 2; frame_y[base + 5] = cy + h + $urandom_range(0, 2);
   endfunction

   // One well-formed frame; the time stamp rides on the twelfth point
   task automatic send_frame(input bit first);
      int r;
      if ($urandom_range(0, 99) < 25)
         closed_mode = !closed_mode;
      fill_eye(0, closed_mode);
      fill_eye(EYE_POINTS, closed_mode);
      r = $urandom_range(0, 99);
      if (r < 55)
         wall_s += $urandom_range(0, 1);
      else if (r < 90)
         wall_s += $urandom_range(2, 5);
      else
         wall_s += $urandom_range(6, 400);
      for (int i = 0; i < FRAME_POINTS; i++)
         send_point(frame_x[i], frame_y[i], first && (i == 0),
                    (i == FRAME_POINTS - 1) ? wall_s : $urandom());
   endtask

   // Frames, broken runs and noise until the point budget is reached
   task automatic run_frames(input int target);
      bit need_first;
      int k;
      need_first = 0;
      while (points_sent < target) begin
         if ($urandom_range(0, 99) < 10) begin
            k = $urandom_range(1, FRAME_POINTS - 1);
            for (int i = 0; i < k; i++)
               send_point($urandom_range(0, 1023), $urandom_range(0, 1023),
                          (i == 0) ? $urandom_range(0, 1) : 1'b0, $urandom());
            need_first = ($urandom_range(0, 9) < 7);
         end else begin
            send_frame(need_first || ($urandom_range(0, 1) == 1));
            need_first = 0;
         end
      end
   endtask

   task automatic run_directed();
      // left eye of zero width: every point at the origin
      for (int i = 0; i < EYE_POINTS; i++)
         send_point(0, 0, i == 0, $urandom());
      // right eye: corners one pixel apart, lids at the far corners, saturating
      send_point(500, 500, 0, $urandom());
      send_point(0, 0, 0, $urandom());
      send_point(1023, 0, 0, $urandom());
      send_point(501, 500, 0, $urandom());
      send_point(0, 1023, 0, $urandom());
      send_point(1023, 1023, 0, 32'hFFFF_FFFF);
      // partial frame, dropped by the restart below
      for (int i = 0; i < 3; i++)
         send_point($urandom_range(0, 1023), $urandom_range(0, 1023), 0, $urandom());
      // closed frame just before the time wraps starts a streak
      wall_s      = 32'hFFFF_FFFE;
      closed_mode = 1;
      send_frame(1);
   endtask

   // Result side: check on every handshake, stall at random
   initial begin
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready)
            sb.match_result(rsp_tdata);
         if (stall > 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            stall = pick_gap();
         end
      end
   end

   // Main sequence: reset, directed frames, then one random phase per setting
   initial begin
      logic [RATIO_W-1:0] thr;
      logic [7:0]         hold;
      reset <= 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      for (int phase = 0; phase < 6; phase++) begin
         if (phase > 0) begin
            wait_idle();
            case (phase)
               1: begin thr = '0;                      hold = 8'd255;                 end
               2: begin thr = '1;                      hold = 8'd0;                   end
               3: begin
                  thr  = RATIO_W'($urandom_range(700, 1000));
                  hold = 8'($urandom_range(0, 4));
               end
               4: begin thr = THRESHOLD_RESET;         hold = 8'd255;                 end
               default: begin
                  thr    = RATIO_W'($urandom_range(0, 4095));
                  hold   = 8'($urandom_range(1, 10));
                  wall_s = $urandom();
               end
            endcase
            write_csr(CSR_RATIO_THRESHOLD, thr);
            write_csr(CSR_HOLD_SECONDS, {8'($urandom_range(0, 255)), hold});
         end
         no_gaps = (phase == 2);
         run_frames((phase + 1) * PHASE_POINTS);
      end
      wait_idle();

      $display("covered %0d points and %0d register writes; %0d frame results checked,",
               points_sent, settings_written, sb.frames_seen);
      $display("%0d of them with eyes closed and %0d with the alarm raised",
               sb.closed_seen, sb.alarms_seen);
      if (sb.errors == 0 && sb.pending_results.size() == 0) begin
         $display("eye_closure_drowsiness_alarm regression: pass");
      end else begin
         $display("eye_closure_drowsiness_alarm regression: fail");
      end
      $finish;
   end

   // Hard stop well beyond the slowest correct run
   initial begin
      #(12_000_000);
      $display("eye_closure_drowsiness_alarm regression: fail");
      $finish;
   end

endmodule
